// File: rtl/lst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lst_pkg;

    localparam int unsigned DOTS_PER_LINE = 456;
    localparam int unsigned VBLANK_LINE   = 144;
    localparam int unsigned LAST_LINE     = 153;
    localparam int unsigned OAM_DOTS      = 80;
    localparam int unsigned XFER_DOTS     = 172;

    localparam int unsigned DOT_W  = 9;
    localparam int unsigned LINE_W = 8;

    localparam logic [1:0] MODE_HBLANK = 2'd0;
    localparam logic [1:0] MODE_VBLANK = 2'd1;
    localparam logic [1:0] MODE_OAM    = 2'd2;
    localparam logic [1:0] MODE_XFER   = 2'd3;

    typedef struct packed {
        logic [7:0] cycles;
        logic       display_on;
        logic [7:0] lyc;
        logic       lyc_int_enable;
    } lst_req_t;

    typedef struct packed {
        logic [7:0] ly;
        logic [1:0] mode;
        logic       coincidence;
        logic       vblank_irq;
        logic       stat_irq;
    } lst_rsp_t;

    typedef struct packed {
        logic [DOT_W-1:0]  dot;
        logic [LINE_W-1:0] line;
        logic              coincidence;
    } lst_state_t;

endpackage

`default_nettype wire

// File: rtl/lst_step.sv
`timescale 1ns / 1ps
`default_nettype none

module lst_step
    import lst_pkg::*;
(
    input  wire lst_state_t state,
    input  wire lst_req_t   req,
    output lst_state_t      state_next,
    output lst_rsp_t        rsp
);

    localparam logic [DOT_W:0]    DOTS_LINE_C = (DOT_W+1)'(DOTS_PER_LINE);
    localparam logic [LINE_W-1:0] VBLANK_C    = LINE_W'(VBLANK_LINE);
    localparam logic [LINE_W-1:0] LAST_C      = LINE_W'(LAST_LINE);
    localparam logic [DOT_W-1:0]  OAM_END_C   = DOT_W'(OAM_DOTS);
    localparam logic [DOT_W-1:0]  XFER_END_C  = DOT_W'(OAM_DOTS + XFER_DOTS);

    logic [DOT_W:0]    dot_sum;
    logic              wrap;
    logic [DOT_W-1:0]  dot_new;
    logic [LINE_W-1:0] line_inc;
    logic [LINE_W-1:0] line_new;
    logic              match;
    logic [1:0]        mode_new;

    // The dot position is always below one line length, so at most one
    // line boundary is crossed per request.
    assign dot_sum  = {1'b0, state.dot} + {{(DOT_W+1-8){1'b0}}, req.cycles};
    assign wrap     = (dot_sum >= DOTS_LINE_C);
    assign dot_new  = wrap ? DOT_W'(dot_sum - DOTS_LINE_C) : dot_sum[DOT_W-1:0];
    assign line_inc = state.line + LINE_W'(1);
    assign line_new = wrap ? ((line_inc > LAST_C) ? '0 : line_inc) : state.line;
    assign match    = (line_new == req.lyc);

    always_comb
    begin
        if (line_new >= VBLANK_C)
            mode_new = MODE_VBLANK;
        else if (dot_new < OAM_END_C)
            mode_new = MODE_OAM;
        else if (dot_new < XFER_END_C)
            mode_new = MODE_XFER;
        else
            mode_new = MODE_HBLANK;
    end

    always_comb
    begin
        if (req.display_on)
        begin
            state_next.dot         = dot_new;
            state_next.line        = line_new;
            state_next.coincidence = match;
            rsp.ly                 = line_new;
            rsp.mode               = mode_new;
            rsp.coincidence        = match;
            rsp.vblank_irq         = wrap && (line_inc == VBLANK_C);
            rsp.stat_irq           = match && req.lyc_int_enable;
        end
        else
        begin
            // Display off: position resets, the compare flag holds.
            state_next.dot         = '0;
            state_next.line        = '0;
            state_next.coincidence = state.coincidence;
            rsp.ly                 = '0;
            rsp.mode               = MODE_HBLANK;
            rsp.coincidence        = state.coincidence;
            rsp.vblank_irq         = 1'b0;
            rsp.stat_irq           = 1'b0;
        end
    end

endmodule

`default_nettype wire

// File: rtl/lcd_scanline_timing.sv
`timescale 1ns / 1ps
`default_nettype none

// LCD line and mode timing. Each request advances the dot position within the
// 456-dot line by its cycle count and returns one response carrying the line
// number, the LCD mode, the line compare flag, a VBlank pulse on entering line
// 144 and a level compare interrupt. A request is captured in an input
// register and then resolved by a single add, compare and increment against
// the timing state, landing in the response register; the block takes one
// request per cycle while req_stall is low, and a response is presented from
// the response register. The input stalls only while both registers are full
// and the output is stalled.

module lcd_scanline_timing
    import lst_pkg::*;
(
    input  wire           clk,
    input  wire           rst_n,
    input  wire           req_valid,
    output logic          req_stall,
    input  wire lst_req_t req,
    output logic          rsp_valid,
    input  wire           rsp_stall,
    output lst_rsp_t      rsp
);

    logic       req_valid_reg;
    lst_req_t   req_reg;
    logic       rsp_valid_reg;
    lst_rsp_t   rsp_reg;
    lst_state_t state_reg;
    lst_state_t state_next;
    lst_rsp_t   rsp_next;
    logic       advance;

    lst_step u_step (
        .state      (state_reg),
        .req        (req_reg),
        .state_next (state_next),
        .rsp        (rsp_next)
    );

    assign advance   = !rsp_valid_reg || !rsp_stall;
    assign req_stall = req_valid_reg && !advance;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (!req_stall)
                req_valid_reg <= req_valid;
            if (advance)
                rsp_valid_reg <= req_valid_reg;
            if (advance && req_valid_reg)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!req_stall && req_valid)
            req_reg <= req;
        if (advance && req_valid_reg)
            rsp_reg <= rsp_next;
    end

endmodule

`default_nettype wire
